// ===== hdl/sacnf_pkg.sv =====
// Shared types and constants for the sACN priority filter and RGB gatherer.
// Used by every module of the block; depends on nothing else.
package sacnf_pkg;

    // Sizes and limits
    localparam int LED_COUNT_DEF = 64;
    localparam int SLOT_MAX      = 512;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    // Register reset values
    localparam logic [15:0] UNIVERSE_RST  = 16'd1;
    localparam logic [9:0]  START_RST     = 10'd1;
    localparam logic [15:0] HOLD_MS_RST   = 16'd2500;
    localparam logic [15:0] KEEPALIVE_RST = 16'd5000;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNIVERSE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEEPALIVE = 3'd4;

    // Input operation codes
    localparam logic [1:0] OP_HEADER = 2'd0;
    localparam logic [1:0] OP_SLOT   = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_LED     = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] packet_universe;
        logic [7:0]  packet_priority;
        logic [9:0]  slot_index;
        logic [7:0]  slot_value;
        logic        slot_last;
    } t_in_word;

    typedef struct packed {
        logic [1:0] result_kind;
        logic       accepted;
        logic [5:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       receiver_active;
        logic       run_end;
    } t_out_word;

    typedef struct packed {
        logic        enable;
        logic [15:0] universe_number;
        logic [9:0]  start_address;
        logic [15:0] hold_ms;
        logic [15:0] keepalive_ms;
    } t_cfg;

endpackage

// ===== hdl/sacn_priority_filter_dmx_to_rgb_unit.sv =====
// sACN receive filter: drops off-universe or lower-priority packets and
// gathers accepted slot bytes into RGB LED words. Each result is registered
// in the output queue; input takes one word a cycle while the queue has room.
// The last slot of a short packet stalls input while the flush sequencer
// emits one black LED a cycle as long as the queue has room.
// Synchronous active-low reset clears control state and configuration.
module sacn_priority_filter_dmx_to_rgb_unit
    import sacnf_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    logic      room;
    logic      push;
    t_out_word word;

    sacnf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sacnf_core #(
        .LED_COUNT (LED_COUNT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_room     (room),
        .o_push     (push),
        .o_word     (word)
    );

    sacnf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (word),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

// ===== hdl/sacnf_cfg.sv =====
// Configuration register file of the sACN filter.
// Depends on sacnf_pkg for register indexes and reset values.
module sacnf_cfg
    import sacnf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Always take a write; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable          <= 1'b0;
            r_cfg.universe_number <= UNIVERSE_RST;
            r_cfg.start_address   <= START_RST;
            r_cfg.hold_ms         <= HOLD_MS_RST;
            r_cfg.keepalive_ms    <= KEEPALIVE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENABLE:    r_cfg.enable          <= i_cfg_data[0];
                REG_UNIVERSE:  r_cfg.universe_number <= i_cfg_data;
                REG_START:     r_cfg.start_address   <= i_cfg_data[9:0];
                REG_HOLD:      r_cfg.hold_ms         <= i_cfg_data;
                REG_KEEPALIVE: r_cfg.keepalive_ms    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hdl/sacnf_core.sv =====
// Packet filter, slot gatherer and black-LED flush sequencer.
// Depends on sacnf_pkg; feeds words into the output queue.
module sacnf_core
    import sacnf_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    input  logic      i_room,
    output logic      o_push,
    output t_out_word o_word
);

    localparam int LW = $clog2(LED_COUNT + 1);

    logic [7:0]    r_prio,      n_prio;
    logic [15:0]   r_elapsed,   n_elapsed;
    logic          r_ever,      n_ever;
    logic          r_open,      n_open;
    logic [LW-1:0] r_next_led,  n_next_led;
    logic [1:0]    r_phase,     n_phase;
    logic [7:0]    r_red,       n_red;
    logic [7:0]    r_green,     n_green;
    logic          r_flush,     n_flush;
    logic [LW-1:0] r_flush_led, n_flush_led;

    logic          accept;
    logic [9:0]    start_eff;
    logic [11:0]   chan;
    logic          capture;
    logic          complete;
    logic [LW-1:0] led_after;
    logic          flush_needed;
    logic [LW-1:0] flush_first;
    logic          seq_start;
    logic          hdr_ok;

    // Stall input while flushing black LEDs or when the queue is full
    assign o_in_ready = i_room && !r_flush;
    assign accept     = i_in_valid && o_in_ready;

    // Expected slot of the current colour and header verdict
    assign start_eff = (i_cfg.start_address == 10'd0) ? 10'd1 : i_cfg.start_address;
    assign chan      = 12'(start_eff) + 12'(r_next_led) + (12'(r_next_led) << 1);
    assign capture   = (r_next_led < LW'(LED_COUNT))
                    && ((chan + 12'd2) <= 12'(SLOT_MAX))
                    && (12'(i_in_word.slot_index) == chan + 12'(r_phase));
    assign complete     = capture && (r_phase == 2'd2);
    assign led_after    = r_next_led + LW'(complete);
    assign flush_needed = i_in_word.slot_last && (led_after < LW'(LED_COUNT));
    assign flush_first  = complete ? led_after : led_after + LW'(1);
    assign seq_start    = flush_needed && (flush_first < LW'(LED_COUNT));
    assign hdr_ok = i_cfg.enable
                 && (i_in_word.packet_universe == i_cfg.universe_number)
                 && !((i_in_word.packet_priority < r_prio) && (r_elapsed < i_cfg.hold_ms));

    always_comb begin
        n_prio      = r_prio;
        n_elapsed   = r_elapsed;
        n_ever      = r_ever;
        n_open      = r_open;
        n_next_led  = r_next_led;
        n_phase     = r_phase;
        n_red       = r_red;
        n_green     = r_green;
        n_flush     = r_flush;
        n_flush_led = r_flush_led;
        o_push      = 1'b0;
        o_word      = '0;

        if (r_flush) begin
            // Emit one black LED a cycle, while the queue has room, until the strip is complete
            if (i_room) begin
                o_push             = 1'b1;
                o_word.result_kind = KIND_LED;
                o_word.led_index   = 6'(r_flush_led);
                o_word.run_end     = (r_flush_led == LW'(LED_COUNT - 1));
                if (r_flush_led == LW'(LED_COUNT - 1)) begin
                    n_flush = 1'b0;
                end else begin
                    n_flush_led = r_flush_led + LW'(1);
                end
            end
        end else if (accept) begin
            unique case (i_in_word.operation)
                OP_HEADER: begin
                    o_push             = 1'b1;
                    o_word.result_kind = KIND_VERDICT;
                    o_word.accepted    = hdr_ok;
                    o_word.run_end     = 1'b1;
                    if (hdr_ok) begin
                        n_prio     = i_in_word.packet_priority;
                        n_elapsed  = '0;
                        n_ever     = 1'b1;
                        n_open     = 1'b1;
                        n_next_led = '0;
                        n_phase    = '0;
                    end
                end
                OP_SLOT: begin
                    if (i_cfg.enable && r_open) begin
                        // Gather the colour byte in order
                        if (capture) begin
                            unique case (r_phase)
                                2'd0: begin
                                    n_red   = i_in_word.slot_value;
                                    n_phase = 2'd1;
                                end
                                2'd1: begin
                                    n_green = i_in_word.slot_value;
                                    n_phase = 2'd2;
                                end
                                default: begin
                                    o_push             = 1'b1;
                                    o_word.result_kind = KIND_LED;
                                    o_word.led_index   = 6'(r_next_led);
                                    o_word.red         = r_red;
                                    o_word.green       = r_green;
                                    o_word.blue        = i_in_word.slot_value;
                                    o_word.run_end     = 1'b1;
                                    n_next_led         = led_after;
                                    n_phase            = 2'd0;
                                end
                            endcase
                        end
                        // Close the packet and start the black flush
                        if (i_in_word.slot_last) begin
                            if (!complete && flush_needed) begin
                                o_push             = 1'b1;
                                o_word.result_kind = KIND_LED;
                                o_word.led_index   = 6'(led_after);
                            end
                            o_word.run_end = !seq_start;
                            n_flush        = seq_start;
                            n_flush_led    = flush_first;
                            n_open         = 1'b0;
                            n_phase        = 2'd0;
                            n_next_led     = led_after;
                        end
                    end
                end
                OP_TICK: begin
                    o_push             = 1'b1;
                    o_word.result_kind = KIND_TICK;
                    o_word.run_end     = 1'b1;
                    if (r_elapsed != ELAPSED_MAX) begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        // Keepalive status as seen after this word
        o_word.receiver_active = i_cfg.enable && n_ever && (n_elapsed < i_cfg.keepalive_ms);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio      <= '0;
            r_elapsed   <= ELAPSED_MAX;
            r_ever      <= 1'b0;
            r_open      <= 1'b0;
            r_next_led  <= '0;
            r_phase     <= '0;
            r_flush     <= 1'b0;
            r_flush_led <= '0;
        end else begin
            r_prio      <= n_prio;
            r_elapsed   <= n_elapsed;
            r_ever      <= n_ever;
            r_open      <= n_open;
            r_next_led  <= n_next_led;
            r_phase     <= n_phase;
            r_flush     <= n_flush;
            r_flush_led <= n_flush_led;
        end
    end

    // Colour holding bytes carry no reset
    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
    end

endmodule

// ===== hdl/sacnf_outq.sv =====
// Two-entry result queue that decouples output stalls from input ready.
// Depends on sacnf_pkg for the result word type.
module sacnf_outq
    import sacnf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_word i_word,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    t_out_word  r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_room  = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_word  = r_mem[r_rd];
    assign push    = i_push && o_room;
    assign pop     = o_valid && i_ready;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    // Store the word
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_word;
        end
    end

endmodule

// ===== hdl/sacnf_checker.sv =====
// Port-level checks for the sACN filter, bound to the top level.
// Depends on sacnf_pkg for word types and codes.
module sacnf_checker
    import sacnf_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_in_word              i_in_word,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_word             o_out_word
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    // A header or tick word always yields a result next cycle
    a_hdr_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready
        && (i_in_word.operation == OP_HEADER || i_in_word.operation == OP_TICK)
        |=> o_out_valid)
        else $error("no result after header or tick");

    // Verdict and tick words carry no colour and end their run
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.result_kind != KIND_LED
        |-> o_out_word.run_end && o_out_word.led_index == 6'd0
            && o_out_word.red == 8'd0 && o_out_word.green == 8'd0
            && o_out_word.blue == 8'd0)
        else $error("status word carries colour data");

    // Only the three defined result kinds appear
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.result_kind == KIND_VERDICT
            || o_out_word.result_kind == KIND_LED
            || o_out_word.result_kind == KIND_TICK)
        else $error("undefined result kind");

endmodule

bind sacn_priority_filter_dmx_to_rgb_unit sacnf_checker u_checker (.*);

// ===== tb/sacn_priority_filter_dmx_to_rgb_unit_test.sv =====
// Self-checking testbench for the sACN priority filter and RGB gatherer.
// Drives packet, slot and tick words, predicts every result word in-bench.
// Depends on sacnf_pkg and sacn_priority_filter_dmx_to_rgb_unit.
`timescale 1ns / 100ps

module sacn_priority_filter_dmx_to_rgb_unit_test;
    import sacnf_pkg::*;

    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam int         QUIET_MAX  = 3000;
    localparam int         RX_HOLDOFF = 300;
    localparam int         PHASES     = 9;
    localparam int         FULL_PHASE = 4;
    localparam int         DARK_PHASE = 5;
    localparam int         PAUSE_PHASE = 2;
    localparam int         PHASE_WORDS = 25;
    localparam int         SETTLE     = 4;

    typedef enum int {GAPS_RX_HEAVY, GAPS_TX_HEAVY, GAPS_NONE} t_gap_mode;
    typedef enum logic [1:0] {COL_RED, COL_GREEN, COL_BLUE} t_colour;
    typedef enum logic {ROW_WORD, ROW_REGS} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_in_word  word;
        bit        typed;
        t_out_word want;
        t_cfg      regs;
        logic [4:0] mask;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor state and register shadow
    t_cfg        cfg_shadow;
    logic [7:0]  src_prio;
    logic [15:0] since_accept;
    bit          ever_taken;
    bit          pkt_open;
    int unsigned led_next;
    t_colour     colour_step;
    logic [7:0]  red_keep;
    logic [7:0]  green_keep;

    t_out_word   due_words[$];
    t_out_word   step_words[$];
    t_stim_row   script[$];
    int          fault_count = 0;
    int          phase_used;
    int          send_gap_pct;
    int          recv_gap_pct;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    sacn_priority_filter_dmx_to_rgb_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Build a result word; the keepalive flag follows the current state
    function automatic t_out_word make_result(logic [1:0] kind, logic acc, logic [5:0] led,
                                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_out_word o;
        o.result_kind     = kind;
        o.accepted        = acc;
        o.led_index       = led;
        o.red             = r;
        o.green           = g;
        o.blue            = b;
        o.receiver_active = cfg_shadow.enable && ever_taken &&
                            (since_accept < cfg_shadow.keepalive_ms);
        o.run_end         = 1'b0;
        return o;
    endfunction

    // Advance the filter by one input word and collect the words it owes
    task automatic predict_filter(input t_in_word w, output bit used);
        int unsigned first_slot;
        int unsigned slot_no;
        bit take;
        step_words.delete();
        used = 1'b1;
        case (w.operation)
            OP_HEADER: begin
                take = cfg_shadow.enable && w.packet_universe == cfg_shadow.universe_number &&
                       !(w.packet_priority < src_prio && since_accept < cfg_shadow.hold_ms);
                if (take) begin
                    src_prio     = w.packet_priority;
                    since_accept = '0;
                    ever_taken   = 1'b1;
                    pkt_open     = 1'b1;
                    led_next     = 0;
                    colour_step  = COL_RED;
                end
                step_words.push_back(make_result(KIND_VERDICT, take, '0, '0, '0, '0));
            end
            OP_SLOT: begin
                if (cfg_shadow.enable && pkt_open) begin
                    first_slot = (cfg_shadow.start_address == 0) ? 1 : cfg_shadow.start_address;
                    slot_no    = first_slot + 3 * led_next;
                    if (led_next < LED_COUNT_DEF && slot_no + 2 <= SLOT_MAX &&
                        w.slot_index == slot_no + colour_step) begin
                        case (colour_step)
                            COL_RED: begin
                                red_keep    = w.slot_value;
                                colour_step = COL_GREEN;
                            end
                            COL_GREEN: begin
                                green_keep  = w.slot_value;
                                colour_step = COL_BLUE;
                            end
                            default: begin
                                step_words.push_back(make_result(KIND_LED, 1'b0, 6'(led_next),
                                                     red_keep, green_keep, w.slot_value));
                                led_next++;
                                colour_step = COL_RED;
                            end
                        endcase
                    end
                    // Flush every LED not yet sent as black, then close
                    if (w.slot_last) begin
                        while (led_next < LED_COUNT_DEF) begin
                            step_words.push_back(make_result(KIND_LED, 1'b0, 6'(led_next),
                                                 '0, '0, '0));
                            led_next++;
                        end
                        pkt_open    = 1'b0;
                        colour_step = COL_RED;
                    end
                end else begin
                    used = 1'b0;
                end
            end
            OP_TICK: begin
                if (since_accept != ELAPSED_MAX)
                    since_accept++;
                step_words.push_back(make_result(KIND_TICK, 1'b0, '0, '0, '0, '0));
            end
            default: used = 1'b0;
        endcase
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].run_end = 1'b1;
    endtask

    // Random filler in the fields the operation does not use
    function automatic t_in_word build_word(logic [1:0] op, logic [15:0] univ, logic [7:0] prio,
                                            logic [9:0] idx, logic [7:0] val, logic last);
        logic [63:0] noise;
        t_in_word w;
        noise = {$urandom, $urandom};
        w = noise[$bits(t_in_word)-1:0];
        w.operation = op;
        if (op == OP_HEADER) begin
            w.packet_universe = univ;
            w.packet_priority = prio;
        end
        if (op == OP_SLOT) begin
            w.slot_index = idx;
            w.slot_value = val;
            w.slot_last  = last;
        end
        return w;
    endfunction

    function automatic t_out_word verdict(logic acc, logic active);
        t_out_word o;
        o = '0;
        o.result_kind     = KIND_VERDICT;
        o.accepted        = acc;
        o.receiver_active = active;
        o.run_end         = 1'b1;
        return o;
    endfunction

    function automatic t_out_word tick_status(logic active);
        t_out_word o;
        o = '0;
        o.result_kind     = KIND_TICK;
        o.receiver_active = active;
        o.run_end         = 1'b1;
        return o;
    endfunction

    function automatic t_stim_row word_row(t_in_word w);
        t_stim_row r;
        r.kind  = ROW_WORD;
        r.word  = w;
        r.typed = 1'b0;
        r.want  = '0;
        r.regs  = '0;
        r.mask  = '0;
        return r;
    endfunction

    function automatic t_stim_row typed_row(t_in_word w, t_out_word want);
        t_stim_row r;
        r       = word_row(w);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_stim_row regs_row(t_cfg c, logic [4:0] mask);
        t_stim_row r;
        r      = word_row('0);
        r.kind = ROW_REGS;
        r.regs = c;
        r.mask = mask;
        return r;
    endfunction

    // Offer one word, hold it until taken, then book what it owes
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word want);
        bit used;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predict_filter(w, used);
        if (used)
            phase_used++;
        if (typed)
            due_words.push_back(want);
        else
            foreach (step_words[k]) due_words.push_back(step_words[k]);
    endtask

    // Drop valid and wait until every owed word has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write the registers picked by mask, valid held high across the burst
    task automatic write_regs(input t_cfg c, input logic [4:0] mask);
        logic [CFG_IDX_W-1:0] ri;
        logic [CFG_DATA_W-1:0] data;
        for (int i = 0; i <= int'(REG_KEEPALIVE); i++) begin
            ri = CFG_IDX_W'(i);
            if (mask[i]) begin
                case (ri)
                    REG_ENABLE:   data = CFG_DATA_W'(c.enable);
                    REG_UNIVERSE: data = c.universe_number;
                    REG_START:    data = CFG_DATA_W'(c.start_address);
                    REG_HOLD:     data = c.hold_ms;
                    default:      data = c.keepalive_ms;
                endcase
                i_cfg_valid <= 1'b1;
                i_cfg_index <= ri;
                i_cfg_data  <= data;
                do @(posedge i_clk); while (!o_cfg_ready);
                case (ri)
                    REG_ENABLE:   cfg_shadow.enable          = c.enable;
                    REG_UNIVERSE: cfg_shadow.universe_number = c.universe_number;
                    REG_START:    cfg_shadow.start_address   = c.start_address;
                    REG_HOLD:     cfg_shadow.hold_ms         = c.hold_ms;
                    default:      cfg_shadow.keepalive_ms    = c.keepalive_ms;
                endcase
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    // One packet: header, optional start code, RGB slots (in order when tidy, ticks between), last slot
    task automatic send_packet(input int n_led, input bit tidy);
        int unsigned idx;
        logic [15:0] univ;
        logic [7:0]  prio;
        univ = ($urandom_range(7) != 0) ? cfg_shadow.universe_number : 16'($urandom);
        case ($urandom_range(3))
            0:       prio = 8'h00;
            1:       prio = 8'hFF;
            default: prio = 8'($urandom);
        endcase
        send_word(build_word(OP_HEADER, univ, prio, '0, '0, 1'b0), 1'b0, '0);
        if ($urandom_range(1))
            send_word(build_word(OP_SLOT, '0, '0, 10'd0, 8'($urandom), 1'b0), 1'b0, '0);
        idx = (cfg_shadow.start_address == 0) ? 1 : cfg_shadow.start_address;
        for (int k = 0; k < 3 * n_led && idx <= SLOT_MAX; k++) begin
            if ($urandom_range(9) == 0)
                send_word(build_word(OP_TICK, '0, '0, '0, '0, 1'b0), 1'b0, '0);
            if (!tidy && $urandom_range(4) == 0) begin
                send_word(build_word(OP_SLOT, '0, '0, 10'($urandom), 8'($urandom), 1'b0),
                          1'b0, '0);
            end else begin
                send_word(build_word(OP_SLOT, '0, '0, 10'(idx), 8'($urandom), 1'b0), 1'b0, '0);
                idx++;
            end
        end
        // Leave a broken packet open now and then for the next header to abandon
        if (!tidy && $urandom_range(2) == 0)
            return;
        case ($urandom_range(2))
            0:       idx = SLOT_MAX;
            1:       idx = $urandom_range(1023);
            default: idx = (idx > SLOT_MAX) ? SLOT_MAX : idx;
        endcase
        send_word(build_word(OP_SLOT, '0, '0, 10'(idx), 8'($urandom), 1'b1), 1'b0, '0);
    endtask

    task automatic set_gaps(input t_gap_mode mode);
        case (mode)
            GAPS_RX_HEAVY: begin
                send_gap_pct = 13;
                recv_gap_pct = 50;
            end
            GAPS_TX_HEAVY: begin
                send_gap_pct = 50;
                recv_gap_pct = 13;
            end
            default: begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
        endcase
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fault_count++;
        end
    endtask

    task automatic check_result(input t_out_word got);
        t_out_word want;
        if (due_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
            fault_count++;
        end else begin
            want = due_words.pop_front();
            compare_field("result_kind", want.result_kind, got.result_kind);
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("led_index", want.led_index, got.led_index);
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("receiver_active", want.receiver_active, got.receiver_active);
            compare_field("run_end", want.run_end, got.run_end);
        end
    endtask

    // Receiver: check each word taken, then pick ready for the next edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_result(o_out_word);
            if (hold_req) begin
                hold_left = RX_HOLDOFF;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    // Watchdog: give up when nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_cfg dcfg;
        t_cfg rcfg;
        bit   paused;
        int   pick;

        // Predictor reset
        cfg_shadow   = '{1'b0, UNIVERSE_RST, START_RST, HOLD_MS_RST, KEEPALIVE_RST};
        src_prio     = '0;
        since_accept = ELAPSED_MAX;
        ever_taken   = 1'b0;
        pkt_open     = 1'b0;
        led_next     = 0;
        colour_step  = COL_RED;
        red_keep     = '0;
        green_keep   = '0;
        set_gaps(GAPS_RX_HEAVY);

        // Directed table
        dcfg = cfg_shadow;
        // disabled after reset: tick, header, stray slot and the spare opcode
        script.push_back(typed_row(build_word(OP_TICK, '0, '0, '0, '0, 1'b0), tick_status(1'b0)));
        script.push_back(typed_row(build_word(OP_HEADER, 16'd1, 8'd0, '0, '0, 1'b0),
                                   verdict(1'b0, 1'b0)));
        script.push_back(word_row(build_word(OP_SLOT, '0, '0, 10'd1, 8'h05, 1'b1)));
        script.push_back(word_row(build_word(OP_SPARE, '0, '0, '0, '0, 1'b0)));
        dcfg.enable          = 1'b1;
        dcfg.universe_number = 16'hFFFF;
        script.push_back(regs_row(dcfg, (5'b1 << REG_ENABLE) | (5'b1 << REG_UNIVERSE)));
        // off-universe drop, then the first source is taken
        script.push_back(typed_row(build_word(OP_HEADER, 16'h0000, 8'hFF, '0, '0, 1'b0),
                                   verdict(1'b0, 1'b0)));
        script.push_back(typed_row(build_word(OP_HEADER, 16'hFFFF, 8'd100, '0, '0, 1'b0),
                                   verdict(1'b1, 1'b1)));
        // start code skipped, one LED gathered, out-of-order slot ignored, rest black
        script.push_back(word_row(build_word(OP_SLOT, '0, '0, 10'd0, 8'h77, 1'b0)));
        script.push_back(word_row(build_word(OP_SLOT, '0, '0, 10'd1, 8'hFF, 1'b0)));
        script.push_back(word_row(build_word(OP_SLOT, '0, '0, 10'd2, 8'h00, 1'b0)));
        script.push_back(word_row(build_word(OP_SLOT, '0, '0, 10'd3, 8'hA5, 1'b0)));
        script.push_back(word_row(build_word(OP_SLOT, '0, '0, 10'd5, 8'h11, 1'b0)));
        script.push_back(word_row(build_word(OP_SLOT, '0, '0, 10'd512, 8'hFF, 1'b1)));
        // lower priority inside the hold time is dropped
        script.push_back(typed_row(build_word(OP_HEADER, 16'hFFFF, 8'd50, '0, '0, 1'b0),
                                   verdict(1'b0, 1'b1)));
        // header abandons an open packet; last slot past the end flushes all black
        script.push_back(word_row(build_word(OP_HEADER, 16'hFFFF, 8'hFF, '0, '0, 1'b0)));
        script.push_back(word_row(build_word(OP_SLOT, '0, '0, 10'd1, 8'h12, 1'b0)));
        script.push_back(word_row(build_word(OP_SLOT, '0, '0, 10'd2, 8'h34, 1'b0)));
        script.push_back(word_row(build_word(OP_HEADER, 16'hFFFF, 8'hFF, '0, '0, 1'b0)));
        script.push_back(word_row(build_word(OP_SLOT, '0, '0, 10'h3FF, 8'h00, 1'b1)));
        // start of zero counts as one; zero hold lets any priority in
        dcfg.start_address = 10'd0;
        dcfg.hold_ms       = 16'd0;
        script.push_back(regs_row(dcfg, (5'b1 << REG_START) | (5'b1 << REG_HOLD)));
        script.push_back(word_row(build_word(OP_HEADER, 16'hFFFF, 8'd0, '0, '0, 1'b0)));
        script.push_back(word_row(build_word(OP_SLOT, '0, '0, 10'd1, 8'hFF, 1'b0)));
        script.push_back(word_row(build_word(OP_SLOT, '0, '0, 10'd2, 8'h80, 1'b0)));
        script.push_back(word_row(build_word(OP_SLOT, '0, '0, 10'd3, 8'hFF, 1'b1)));
        // start past 510 leaves every LED black; zero keepalive never counts active
        dcfg.start_address   = 10'd512;
        dcfg.keepalive_ms    = 16'd0;
        dcfg.universe_number = 16'h0000;
        script.push_back(regs_row(dcfg, (5'b1 << REG_START) | (5'b1 << REG_KEEPALIVE) |
                                        (5'b1 << REG_UNIVERSE)));
        script.push_back(word_row(build_word(OP_HEADER, 16'h0000, 8'd0, '0, '0, 1'b0)));
        script.push_back(word_row(build_word(OP_SLOT, '0, '0, 10'd512, 8'hFF, 1'b1)));
        script.push_back(typed_row(build_word(OP_TICK, '0, '0, '0, '0, 1'b0), tick_status(1'b0)));

        // Hold reset, then walk the table
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (script[i]) begin
            if (script[i].kind == ROW_REGS) begin
                wait_drained();
                write_regs(script[i].regs, script[i].mask);
            end else begin
                send_word(script[i].word, script[i].typed, script[i].want);
            end
        end

        // Random phases, each under fresh register values
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            set_gaps(t_gap_mode'(p * 3 / PHASES));
            rcfg.enable = (p != DARK_PHASE);
            case ($urandom_range(2))
                0:       rcfg.universe_number = 16'h0000;
                1:       rcfg.universe_number = 16'hFFFF;
                default: rcfg.universe_number = 16'($urandom);
            endcase
            case ($urandom_range(5))
                0:       rcfg.start_address = 10'd0;
                1:       rcfg.start_address = 10'd1;
                2:       rcfg.start_address = 10'd510;
                3:       rcfg.start_address = 10'd511;
                4:       rcfg.start_address = 10'd512;
                default: rcfg.start_address = 10'($urandom_range(512));
            endcase
            case ($urandom_range(3))
                0:       rcfg.hold_ms = 16'd0;
                1:       rcfg.hold_ms = 16'd1;
                2:       rcfg.hold_ms = 16'hFFFF;
                default: rcfg.hold_ms = 16'($urandom_range(2, 20));
            endcase
            case ($urandom_range(3))
                0:       rcfg.keepalive_ms = 16'd0;
                1:       rcfg.keepalive_ms = 16'd1;
                2:       rcfg.keepalive_ms = 16'hFFFF;
                default: rcfg.keepalive_ms = 16'($urandom_range(2, 40));
            endcase
            if (p == FULL_PHASE)
                rcfg.start_address = 10'd1;
            write_regs(rcfg, '1);
            phase_used = 0;
            paused     = 1'b0;

            // Stall the receiver while a full 64-LED packet is pushed in
            if (p == FULL_PHASE) begin
                hold_req = 1'b1;
                send_packet(LED_COUNT_DEF, 1'b1);
            end

            while (phase_used < PHASE_WORDS) begin
                if (p == PAUSE_PHASE && !paused && phase_used >= PHASE_WORDS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                pick = $urandom_range(19);
                if (pick < 3) begin
                    send_word(build_word(2'($urandom), 16'($urandom), 8'($urandom),
                                         10'($urandom), 8'($urandom), 1'($urandom)), 1'b0, '0);
                end else if (pick < 6) begin
                    // long bursts let the hold and keepalive times run out
                    repeat ((pick == 5) ? 30 : $urandom_range(1, 4))
                        send_word(build_word(OP_TICK, '0, '0, '0, '0, 1'b0), 1'b0, '0);
                end else begin
                    send_packet($urandom_range(0, 5), $urandom_range(9) != 0);
                end
            end
        end

        wait_drained();
        if (fault_count == 0 && due_words.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
